// File: sv/mlprs_pkg.sv
// Shared types, codes and defaults of the page-mode LCD refresh sequencer.
package mlprs_pkg;

  // Default sizing of the frame store.
  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_PAGES = 16;

  // Port widths fixed by the field definitions.
  localparam int CMD_W      = 2;
  localparam int ADDR_IN_W  = 12;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Input transaction commands.
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SLOT    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd3;

  // Controller kinds.
  localparam logic [1:0] KIND_GENERIC = 2'd0;
  localparam logic [1:0] KIND_PAGE2   = 2'd1;
  localparam logic [1:0] KIND_WINDOW  = 2'd2;
  localparam logic [1:0] KIND_ALIAS   = 2'd3;

  // Rotation code that shifts the column start on the generic controller.
  localparam logic [1:0] ROT_SHIFTED = 2'd2;
  localparam logic [7:0] COL_SHIFT   = 8'd4;

  // Register reset values.
  localparam logic [1:0] RST_KIND     = 2'd0;
  localparam logic [8:0] RST_WIDTH    = 9'd128;
  localparam logic [7:0] RST_HEIGHT   = 8'd64;
  localparam logic [1:0] RST_ROTATION = 2'd0;

  // Controller command bytes.
  localparam logic [7:0] BYTE_ROW_ADDR  = 8'h75;
  localparam logic [7:0] BYTE_COL_ADDR  = 8'h15;
  localparam logic [7:0] BYTE_MEM_WRITE = 8'h5C;
  localparam logic [7:0] BYTE_PAGE2_Y   = 8'h40;
  localparam logic [7:0] BYTE_PAGE2_X   = 8'h80;
  localparam logic [7:0] BYTE_COL_MSB   = 8'h10;
  localparam logic [7:0] BYTE_PAGE_BASE = 8'hB0;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] PAGE_MASK      = 8'h0F;

  // Window set-up sequence positions.
  localparam logic [2:0] WIN_ROW_CMD  = 3'd0;
  localparam logic [2:0] WIN_ROW_LO   = 3'd1;
  localparam logic [2:0] WIN_ROW_HI   = 3'd2;
  localparam logic [2:0] WIN_COL_CMD  = 3'd3;
  localparam logic [2:0] WIN_COL_LO   = 3'd4;
  localparam logic [2:0] WIN_COL_HI   = 3'd5;
  localparam logic [2:0] WIN_LAST     = 3'd6;

  // Sequencer phase.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PAGECMD,
    PH_WINDOW,
    PH_DATA
  } phase_t;

endpackage

// File: sv/mlprs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mlprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/mono_lcd_page_refresh_sequencer.sv
// Top level of the page-mode monochrome LCD refresh sequencer.
//
// Software fills a page-organized frame store (address page*width+column) with store-write
// transactions and then issues an update request; each following slot transaction yields one
// SPI byte with its command/data level, a chip-select release mark and an update-done flag.
// One input transaction is accepted every cycle while the result side keeps up. A result
// passes through the read stage, where the frame-store read port (registered read) completes,
// and then through the output register. in_stall rises only while a result is held in the
// output register and a second one is waiting in the read stage. The frame store has no
// clearing pass and is available right after reset. Requests made during an update collapse
// into one pending update that starts as soon as the current update ends.
module mono_lcd_page_refresh_sequencer #(
  parameter int MAX_WIDTH = mlprs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_PAGES = mlprs_pkg::DEF_MAX_PAGES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mlprs_pkg::CMD_W-1:0]        in_command,
  input  logic [mlprs_pkg::ADDR_IN_W-1:0]    in_store_addr,
  input  logic [mlprs_pkg::BYTE_W-1:0]       in_store_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mlprs_pkg::BYTE_W-1:0]       out_spi_byte,
  output logic                               out_data_not_command,
  output logic                               out_frame_last,
  output logic                               out_update_done,
  input  logic                               cfg_we,
  input  logic [mlprs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlprs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import mlprs_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_PAGES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int PAGE_W      = $clog2(MAX_PAGES + 1);
  localparam int LIN_W       = 14;

  // Configuration registers.
  logic [1:0] kind_r;
  logic [8:0] width_r;
  logic [7:0] height_r;
  logic [1:0] rot_r;

  // Sequencer state.
  phase_t            phase_r, phase_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [2:0]        cmd_idx_r, cmd_idx_nxt;
  logic              pending_r, pending_nxt;

  // Read stage and output register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_ram_r, s1_dc_r, s1_last_r, s1_done_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_dc_r, out_last_r, out_done_r;

  // Combinational sequencer outputs.
  logic              accept, out_load, start_upd;
  logic              seq_vld, seq_ram, seq_dc, seq_last, seq_done;
  logic [7:0]        seq_byte;
  logic              ram_we, ram_re;
  logic [7:0]        ram_q;
  logic [ADDR_W-1:0] ram_raddr;

  // Effective register values after clamping.
  logic [1:0]       kind_eff;
  logic [8:0]       width_eff;
  logic [7:0]       height_eff;
  logic [4:0]       pages_eff;
  logic [LIN_W-1:0] lin_addr;
  logic [9:0]       col_plus;
  logic [5:0]       page_plus;
  logic [3:0]       cmd_plus;
  logic [3:0]       cmd_count;
  logic [7:0]       page_byte;

  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_load;
  assign accept   = in_valid && !in_stall;

  assign kind_eff   = (kind_r == KIND_ALIAS) ? KIND_GENERIC : kind_r;
  assign width_eff  = (width_r == 9'd0) ? 9'd1 :
                      (width_r > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_r;
  assign height_eff = (height_r < 8'd8) ? 8'd8 :
                      (height_r > 8'(MAX_PAGES * 8)) ? 8'(MAX_PAGES * 8) : height_r;
  assign pages_eff  = height_eff[7:3];
  assign lin_addr   = LIN_W'(page_r) * LIN_W'(width_eff) + LIN_W'(col_r);
  assign col_plus   = 10'(col_r) + 10'd1;
  assign page_plus  = 6'(page_r) + 6'd1;
  assign cmd_plus   = 4'(cmd_idx_r) + 4'd1;
  assign cmd_count  = (kind_eff == KIND_PAGE2) ? 4'd2 : 4'd3;
  assign page_byte  = 8'(page_r) & PAGE_MASK;
  assign ram_raddr  = lin_addr[ADDR_W-1:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= RST_KIND;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      rot_r    <= RST_ROTATION;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KIND:     kind_r   <= cfg_data[1:0];
        CFG_WIDTH:    width_r  <= cfg_data;
        CFG_HEIGHT:   height_r <= cfg_data[7:0];
        CFG_ROTATION: rot_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Next-state and byte selection for one accepted transaction.
  always_comb begin
    phase_nxt   = phase_r;
    page_nxt    = page_r;
    col_nxt     = col_r;
    cmd_idx_nxt = cmd_idx_r;
    pending_nxt = pending_r;
    start_upd   = 1'b0;
    seq_vld     = 1'b0;
    seq_ram     = 1'b0;
    seq_byte    = BYTE_ZERO;
    seq_dc      = 1'b0;
    seq_last    = 1'b0;
    seq_done    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (accept) begin
      case (in_command)
        CMD_WRITE: begin
          ram_we = (13'(in_store_addr) < 13'(STORE_DEPTH));
        end
        CMD_REQUEST: begin
          if (phase_r == PH_IDLE) begin
            start_upd = 1'b1;
          end else begin
            pending_nxt = 1'b1;
          end
        end
        CMD_SLOT: begin
          case (phase_r)
            PH_WINDOW: begin
              seq_vld  = 1'b1;
              seq_last = 1'b1;
              case (cmd_idx_r)
                WIN_ROW_CMD: seq_byte = BYTE_ROW_ADDR;
                WIN_ROW_LO: begin
                  seq_byte = BYTE_ZERO;
                  seq_dc   = 1'b1;
                end
                WIN_ROW_HI: begin
                  seq_byte = 8'((height_eff - 8'd1) >> 3);
                  seq_dc   = 1'b1;
                end
                WIN_COL_CMD: seq_byte = BYTE_COL_ADDR;
                WIN_COL_LO: begin
                  seq_byte = BYTE_ZERO;
                  seq_dc   = 1'b1;
                end
                WIN_COL_HI: begin
                  seq_byte = 8'(width_eff - 9'd1);
                  seq_dc   = 1'b1;
                end
                default: seq_byte = BYTE_MEM_WRITE;
              endcase
              if (cmd_idx_r >= WIN_LAST) begin
                cmd_idx_nxt = 3'd0;
                col_nxt     = '0;
                phase_nxt   = PH_DATA;
              end else begin
                cmd_idx_nxt = cmd_idx_r + 3'd1;
              end
            end
            PH_PAGECMD: begin
              seq_vld = 1'b1;
              if (kind_eff == KIND_PAGE2) begin
                seq_byte = (cmd_idx_r == 3'd0) ? (BYTE_PAGE2_Y | page_byte) : BYTE_PAGE2_X;
              end else if (cmd_idx_r == 3'd0) begin
                seq_byte = (rot_r == ROT_SHIFTED) ? COL_SHIFT : BYTE_ZERO;
              end else if (cmd_idx_r == 3'd1) begin
                seq_byte = BYTE_COL_MSB;
              end else begin
                seq_byte = BYTE_PAGE_BASE + page_byte;
              end
              if (cmd_plus >= cmd_count) begin
                seq_last    = 1'b1;
                cmd_idx_nxt = 3'd0;
                col_nxt     = '0;
                phase_nxt   = PH_DATA;
              end else begin
                cmd_idx_nxt = cmd_idx_r + 3'd1;
              end
            end
            PH_DATA: begin
              seq_vld = 1'b1;
              seq_dc  = 1'b1;
              // Reads outside the store give zero.
              if (lin_addr < LIN_W'(STORE_DEPTH)) begin
                ram_re  = 1'b1;
                seq_ram = 1'b1;
              end
              if (col_plus >= 10'(width_eff)) begin
                seq_last = 1'b1;
                col_nxt  = '0;
                if (page_plus >= 6'(pages_eff)) begin
                  seq_done = 1'b1;
                  if (pending_r) begin
                    pending_nxt = 1'b0;
                    start_upd   = 1'b1;
                  end else begin
                    phase_nxt = PH_IDLE;
                    page_nxt  = '0;
                  end
                end else begin
                  page_nxt    = PAGE_W'(page_plus);
                  cmd_idx_nxt = 3'd0;
                  phase_nxt   = (kind_eff == KIND_WINDOW) ? PH_DATA : PH_PAGECMD;
                end
              end else begin
                col_nxt = COL_W'(col_plus);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      // Start of a new update, from a request or from a pending one.
      if (start_upd) begin
        page_nxt    = '0;
        col_nxt     = '0;
        cmd_idx_nxt = 3'd0;
        phase_nxt   = (kind_eff == KIND_WINDOW) ? PH_WINDOW : PH_PAGECMD;
      end
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      page_r    <= '0;
      col_r     <= '0;
      cmd_idx_r <= 3'd0;
      pending_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      page_r    <= page_nxt;
      col_r     <= col_nxt;
      cmd_idx_r <= cmd_idx_nxt;
      pending_r <= pending_nxt;
    end
  end

  // Frame store.
  mlprs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_store_addr[ADDR_W-1:0]),
    .wdata (in_store_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Read stage: holds the result while the store read completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= seq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= seq_byte;
      s1_ram_r  <= seq_ram;
      s1_dc_r   <= seq_dc;
      s1_last_r <= seq_last;
      s1_done_r <= seq_done;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= s1_ram_r ? ram_q : s1_byte_r;
      out_dc_r   <= s1_dc_r;
      out_last_r <= s1_last_r;
      out_done_r <= s1_done_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_spi_byte         = out_byte_r;
  assign out_data_not_command = out_dc_r;
  assign out_frame_last       = out_last_r;
  assign out_update_done      = out_done_r;

  // A stall is only raised with both result stages full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled without a full result pipeline");

  // No update can be pending while the sequencer is idle.
  a_idle_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> !pending_r)
    else $error("pending update left while idle");

  // The end of an update is always a data byte that closes its frame.
  a_done_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_dc_r && out_last_r))
    else $error("update end on a byte that is not a closing data byte");

  // The window sequence never runs past its last byte.
  a_window_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WINDOW) |-> (cmd_idx_r <= WIN_LAST))
    else $error("window set-up index out of range");

endmodule

// File: tb/tb_mono_lcd_page_refresh_sequencer.sv
// Self-checking testbench for the page-mode monochrome LCD refresh sequencer.
`timescale 1ns / 1ps

module tb_mono_lcd_page_refresh_sequencer;
  import mlprs_pkg::*;

  // Command value that the block ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned RAND_ITEMS    = 1300;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STUCK_LIMIT   = 2000;
  localparam int unsigned STORE_DEPTH   = DEF_MAX_WIDTH * DEF_MAX_PAGES;

  // One SPI byte as it leaves the block.
  typedef struct packed {
    logic [7:0] spi_byte;
    logic       dnc;
    logic       frame_last;
    logic       update_done;
  } lcd_byte_t;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_FIXED,
    CHK_NONE
  } row_check_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [ADDR_IN_W-1:0] addr;
    logic [BYTE_W-1:0]    byt;
    row_check_t           chk;
    lcd_byte_t            want;
  } stim_row_t;

  // Directed rows, run on a generic controller, 4 columns, one page, shifted rotation.
  localparam stim_row_t DIR_ROWS [26] = '{
    '{CMD_SLOT,    12'h000, 8'h00, CHK_NONE,  '0},                        // slot while idle
    '{CMD_UNUSED,  12'hFFF, 8'hFF, CHK_NONE,  '0},                        // ignored command
    '{CMD_WRITE,   12'h000, 8'h00, CHK_NONE,  '0},
    '{CMD_WRITE,   12'h001, 8'hFF, CHK_NONE,  '0},
    '{CMD_WRITE,   12'h002, 8'hA5, CHK_NONE,  '0},
    '{CMD_WRITE,   12'h003, 8'h5A, CHK_NONE,  '0},
    '{CMD_WRITE,   12'hFFF, 8'hFF, CHK_NONE,  '0},                        // top of the store
    '{CMD_REQUEST, 12'h000, 8'h00, CHK_NONE,  '0},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_FIXED, '{8'h04, 1'b0, 1'b0, 1'b0}},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_FIXED, '{8'h10, 1'b0, 1'b0, 1'b0}},
    '{CMD_REQUEST, 12'h000, 8'h00, CHK_NONE,  '0},                        // request while busy
    '{CMD_SLOT,    12'h000, 8'h00, CHK_FIXED, '{8'hB0, 1'b0, 1'b1, 1'b0}},
    '{CMD_REQUEST, 12'hFFF, 8'hFF, CHK_NONE,  '0},                        // collapses into one
    '{CMD_SLOT,    12'h000, 8'h00, CHK_FIXED, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{CMD_WRITE,   12'h003, 8'h3C, CHK_NONE,  '0},                        // byte not yet sent
    '{CMD_SLOT,    12'h000, 8'h00, CHK_FIXED, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_FIXED, '{8'hA5, 1'b1, 1'b0, 1'b0}},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_FIXED, '{8'h3C, 1'b1, 1'b1, 1'b1}},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_MODEL, '0},                        // pending update
    '{CMD_SLOT,    12'hFFF, 8'hFF, CHK_MODEL, '0},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_MODEL, '0},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_MODEL, '0},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_MODEL, '0},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_MODEL, '0},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_MODEL, '0},
    '{CMD_SLOT,    12'h000, 8'h00, CHK_NONE,  '0}                         // idle again
  };

  localparam int unsigned WIDE_PICKS [6] = '{0, 1, 255, 256, 257, 511};
  localparam int unsigned TALL_PICKS [7] = '{0, 7, 8, 127, 128, 129, 255};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command;
  logic [ADDR_IN_W-1:0]  in_store_addr;
  logic [BYTE_W-1:0]     in_store_byte;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_spi_byte;
  logic                  out_data_not_command;
  logic                  out_frame_last;
  logic                  out_update_done;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow of the sequencer: frame store, progress and registers.
  logic [7:0]  frame_mem [STORE_DEPTH];
  bit          frame_written [STORE_DEPTH];
  phase_t      seq_phase;
  logic [4:0]  seq_page;
  logic [8:0]  seq_col;
  logic [2:0]  seq_cmd_pos;
  logic        seq_pending;
  logic [1:0]  cfg_kind_r;
  logic [8:0]  cfg_width_r;
  logic [7:0]  cfg_height_r;
  logic [1:0]  cfg_rot_r;

  lcd_byte_t   lcd_byte_q [$];
  lcd_byte_t   head_byte;
  bit          idle_en = 1'b1;
  int unsigned fail_count = 0;
  int unsigned work_items = 0;
  int unsigned stuck_cycles = 0;

  mono_lcd_page_refresh_sequencer u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_store_addr        (in_store_addr),
    .in_store_byte        (in_store_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_spi_byte         (out_spi_byte),
    .out_data_not_command (out_data_not_command),
    .out_frame_last       (out_frame_last),
    .out_update_done      (out_update_done),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Register values as the block uses them, with out-of-range settings clamped.
  function automatic logic [1:0] ctrl_kind();
    return (cfg_kind_r == KIND_ALIAS) ? KIND_GENERIC : cfg_kind_r;
  endfunction

  function automatic int unsigned panel_cols();
    if (cfg_width_r == 0) return 1;
    if (cfg_width_r > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return cfg_width_r;
  endfunction

  function automatic int unsigned panel_rows();
    if (cfg_height_r < 8) return 8;
    if (cfg_height_r > DEF_MAX_PAGES * 8) return DEF_MAX_PAGES * 8;
    return cfg_height_r;
  endfunction

  function automatic int unsigned panel_pages();
    return panel_rows() >> 3;
  endfunction

  function automatic lcd_byte_t lcd_byte(input logic [7:0] b, input logic dnc,
                                         input logic last, input logic done);
    return '{b, dnc, last, done};
  endfunction

  function automatic void begin_update();
    seq_page    = '0;
    seq_col     = '0;
    seq_cmd_pos = '0;
    seq_phase   = (ctrl_kind() == KIND_WINDOW) ? PH_WINDOW : PH_PAGECMD;
  endfunction

  // Advances the shadow sequencer by one input transaction; returns 1 when an SPI byte results.
  function automatic bit lcd_seq_step(input logic [CMD_W-1:0] cmd,
                                      input logic [ADDR_IN_W-1:0] addr,
                                      input logic [BYTE_W-1:0] byt, output lcd_byte_t res);
    int unsigned cols;
    int unsigned mem_addr;
    logic [3:0]  pg;
    logic [7:0]  b;
    bit          cmd_last;
    bit          row_end;
    bit          final_page;
    res  = '0;
    cols = panel_cols();
    pg   = seq_page[3:0];
    if (cmd == CMD_WRITE) begin
      frame_mem[addr]     = byt;
      frame_written[addr] = 1'b1;
      return 1'b0;
    end
    if (cmd == CMD_REQUEST) begin
      if (seq_phase == PH_IDLE) begin_update();
      else seq_pending = 1'b1;
      return 1'b0;
    end
    if (cmd != CMD_SLOT || seq_phase == PH_IDLE) return 1'b0;

    case (seq_phase)
      // One-time window set-up, every byte in a frame of its own.
      PH_WINDOW: begin
        case (seq_cmd_pos)
          WIN_ROW_CMD: res = lcd_byte(BYTE_ROW_ADDR, 1'b0, 1'b1, 1'b0);
          WIN_ROW_LO:  res = lcd_byte(BYTE_ZERO, 1'b1, 1'b1, 1'b0);
          WIN_ROW_HI:  res = lcd_byte(8'((panel_rows() - 1) >> 3), 1'b1, 1'b1, 1'b0);
          WIN_COL_CMD: res = lcd_byte(BYTE_COL_ADDR, 1'b0, 1'b1, 1'b0);
          WIN_COL_LO:  res = lcd_byte(BYTE_ZERO, 1'b1, 1'b1, 1'b0);
          WIN_COL_HI:  res = lcd_byte(8'(cols - 1), 1'b1, 1'b1, 1'b0);
          default:     res = lcd_byte(BYTE_MEM_WRITE, 1'b0, 1'b1, 1'b0);
        endcase
        if (seq_cmd_pos >= WIN_LAST) begin
          seq_cmd_pos = '0;
          seq_col     = '0;
          seq_phase   = PH_DATA;
        end else begin
          seq_cmd_pos = seq_cmd_pos + 1'b1;
        end
      end
      // Per-page address commands, all in one frame.
      PH_PAGECMD: begin
        if (ctrl_kind() == KIND_PAGE2)
          b = (seq_cmd_pos == 0) ? (BYTE_PAGE2_Y | {4'h0, pg}) : BYTE_PAGE2_X;
        else if (seq_cmd_pos == 0)
          b = (cfg_rot_r == ROT_SHIFTED) ? COL_SHIFT : BYTE_ZERO;
        else if (seq_cmd_pos == 1)
          b = BYTE_COL_MSB;
        else
          b = BYTE_PAGE_BASE + {4'h0, pg};
        cmd_last = (int'(seq_cmd_pos) + 1 >= ((ctrl_kind() == KIND_PAGE2) ? 2 : 3));
        res = lcd_byte(b, 1'b0, cmd_last, 1'b0);
        if (cmd_last) begin
          seq_cmd_pos = '0;
          seq_col     = '0;
          seq_phase   = PH_DATA;
        end else begin
          seq_cmd_pos = seq_cmd_pos + 1'b1;
        end
      end
      // One page row of data bytes; the last byte closes the frame.
      default: begin
        mem_addr   = int'(seq_page) * cols + int'(seq_col);
        row_end    = (int'(seq_col) + 1 >= cols);
        final_page = (int'(seq_page) + 1 >= panel_pages());
        res = lcd_byte(frame_mem[mem_addr], 1'b1, row_end, row_end && final_page);
        if (!row_end) begin
          seq_col = seq_col + 1'b1;
        end else begin
          seq_col = '0;
          if (final_page) begin
            if (seq_pending) begin
              seq_pending = 1'b0;
              begin_update();
            end else begin
              seq_phase = PH_IDLE;
              seq_page  = '0;
            end
          end else begin
            seq_page    = seq_page + 1'b1;
            seq_cmd_pos = '0;
            seq_phase   = (ctrl_kind() == KIND_WINDOW) ? PH_DATA : PH_PAGECMD;
          end
        end
      end
    endcase
    return 1'b1;
  endfunction

  // Offers one input transaction, with random idle cycles ahead of it, and records what it causes.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_IN_W-1:0] addr,
                           input logic [BYTE_W-1:0] byt, input row_check_t chk = CHK_MODEL,
                           input lcd_byte_t fixed = '0);
    lcd_byte_t res;
    bit        has;
    while (idle_en && ($urandom_range(99) < 24)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_store_addr <= addr;
    in_store_byte <= byt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = lcd_seq_step(cmd, addr, byt, res);
    case (chk)
      CHK_MODEL: if (has) lcd_byte_q.push_back(res);
      CHK_FIXED: lcd_byte_q.push_back(fixed);
      default: ;
    endcase
    if (cmd != CMD_UNUSED && (cmd != CMD_SLOT || has)) work_items++;
    @(negedge clk);
  endtask

  // Holds the input channel until every expected byte is out, then waits some more.
  task automatic drain_results(input int unsigned extra);
    in_valid <= 1'b0;
    @(negedge clk);
    while (lcd_byte_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    case (idx)
      CFG_KIND:   cfg_kind_r   = val[1:0];
      CFG_WIDTH:  cfg_width_r  = val[8:0];
      CFG_HEIGHT: cfg_height_r = val[7:0];
      default:    cfg_rot_r    = val[1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic program_panel(input logic [1:0] kind, input int unsigned w,
                               input int unsigned h, input logic [1:0] rot);
    write_reg(CFG_KIND, kind);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_ROTATION, rot);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One panel setting: fill the frame, run updates with writes and requests mixed in, finish.
  task automatic run_refresh_phase(input int unsigned w, input int unsigned h,
                                   input bit any_size, input bit hold_mid);
    logic [1:0]  kind;
    logic [1:0]  rot;
    int unsigned n;
    int unsigned r;
    int unsigned a;
    kind = 2'($urandom_range(3));
    rot  = 2'($urandom_range(3));
    drain_results(SETTLE_CYCLES);
    program_panel(kind, w, h, rot);
    if (!any_size && panel_cols() * panel_pages() > 320)
      program_panel(kind, w, $urandom_range(15), rot);

    // Every byte this frame reads gets written before the first request.
    for (a = 0; a < panel_cols() * panel_pages(); a++)
      if (!frame_written[a]) send_item(CMD_WRITE, ADDR_IN_W'(a), 8'($urandom));

    if ($urandom_range(9) == 0) send_item(CMD_SLOT, 12'($urandom), 8'($urandom));
    send_item(CMD_REQUEST, 12'($urandom), 8'($urandom));
    n = $urandom_range(10, 50);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if ((hold_mid && k == n / 2) || r < 2) drain_results(0);
      if (r < 60)      send_item(CMD_SLOT, 12'($urandom), 8'($urandom));
      else if (r < 80) send_item(CMD_WRITE, 12'($urandom), 8'($urandom));
      else if (r < 90) send_item(CMD_REQUEST, 12'($urandom), 8'($urandom));
      else             send_item(CMD_UNUSED, 12'($urandom), 8'($urandom));
    end
    while (seq_phase != PH_IDLE) send_item(CMD_SLOT, 12'($urandom), 8'($urandom));
  endtask

  // The result side stalls at random while idle cycles are enabled.
  always @(negedge clk) out_stall <= idle_en && ($urandom_range(99) < 24);

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Each accepted result transaction is compared with the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (lcd_byte_q.size() == 0) begin
        $error("out_spi_byte: unexpected result 0x%0h with nothing pending", out_spi_byte);
        fail_count++;
      end else begin
        head_byte = lcd_byte_q.pop_front();
        check_field("out_spi_byte", head_byte.spi_byte, out_spi_byte);
        check_field("out_data_not_command", head_byte.dnc, out_data_not_command);
        check_field("out_frame_last", head_byte.frame_last, out_frame_last);
        check_field("out_update_done", head_byte.update_done, out_update_done);
      end
    end
  end

  // Ends the run when neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Reset, directed rows, random phases, then out-of-range width and height settings.
  initial begin
    int unsigned phase_no;
    int unsigned w;
    int unsigned h;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_WRITE;
    in_store_addr = '0;
    in_store_byte = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_KIND;
    cfg_data      = '0;
    seq_phase     = PH_IDLE;
    seq_page      = '0;
    seq_col       = '0;
    seq_cmd_pos   = '0;
    seq_pending   = 1'b0;
    cfg_kind_r    = RST_KIND;
    cfg_width_r   = RST_WIDTH;
    cfg_height_r  = RST_HEIGHT;
    cfg_rot_r     = RST_ROTATION;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    program_panel(KIND_GENERIC, 4, 8, ROT_SHIFTED);
    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].addr, DIR_ROWS[i].byt, DIR_ROWS[i].chk,
                DIR_ROWS[i].want);

    work_items = 0;
    phase_no   = 0;
    while (work_items < RAND_ITEMS) begin
      // A few phases in a row run with no idle cycles on either side.
      idle_en = !(phase_no >= 6 && phase_no <= 8);
      case (phase_no)
        3: run_refresh_phase(256, 8, 1'b1, 1'b0);
        5: run_refresh_phase(1, 128, 1'b1, 1'b0);
        default: begin
          w = ($urandom_range(99) < 10) ? WIDE_PICKS[$urandom_range(5)] : $urandom_range(1, 16);
          h = ($urandom_range(99) < 10) ? TALL_PICKS[$urandom_range(6)] : $urandom_range(0, 40);
          run_refresh_phase(w, h, 1'b0, phase_no == 2);
        end
      endcase
      phase_no++;
    end
    idle_en = 1'b1;
    run_refresh_phase(511, 255, 1'b0, 1'b0);
    drain_results(SETTLE_CYCLES);

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
sv/mlprs_pkg.sv
sv/mlprs_ram.sv
sv/mono_lcd_page_refresh_sequencer.sv
tb/tb_mono_lcd_page_refresh_sequencer.sv
